@@ design/xcfr_pkg.sv @@
// Shared constants and controller/datapath interface types for the frame receiver.
`timescale 1ns / 1ps

package xcfr_pkg;

   localparam int unsigned MAX_PAYLOAD_DEFAULT = 32;
   localparam logic [7:0]  HEAD_RESET          = 8'hAA;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LENGTH_W   = 6;
   localparam int unsigned INDEX_W    = 5;
   localparam int unsigned RSP_DATA_W = 32;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic start_frame;   // head seen: seed checksum with head value
      logic take_command;
      logic take_length;
      logic take_payload;
      logic fetch_first;   // read payload entry 0, clear output index
      logic fetch_next;    // step output index, read following entry
   } xcfr_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic head_hit;      // incoming byte equals head register
      logic length_over;   // incoming length exceeds the payload limit
      logic length_zero;   // incoming length is zero
      logic payload_done;  // this payload byte is the final one
      logic check_ok;      // incoming byte equals running checksum
      logic rsp_last;      // word on the output is the last of the frame
   } xcfr_status_type;

endpackage

@@ design/xcfr_ctrl.sv @@
// Frame parsing and playout state machine.
`timescale 1ns / 1ps

module xcfr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  xcfr_pkg::xcfr_status_type status_in,
   output xcfr_pkg::xcfr_cmd_type    cmd_out
);
   import xcfr_pkg::*;

   typedef enum logic [5:0] {
      S_HEAD = 6'b000001,
      S_CMD  = 6'b000010,
      S_LEN  = 6'b000100,
      S_DATA = 6'b001000,
      S_CHK  = 6'b010000,
      S_SHOW = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      req_fire;
   logic      rsp_fire;

   assign req_tready = (state_ff != S_SHOW);
   assign rsp_tvalid = (state_ff == S_SHOW);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd_out  = '0;
      unique case (state_ff)
         S_HEAD: begin
            if (req_fire && status_in.head_hit) begin
               cmd_out.start_frame = 1'b1;
               state_in            = S_CMD;
            end
         end
         S_CMD: begin
            if (req_fire) begin
               cmd_out.take_command = 1'b1;
               state_in             = S_LEN;
            end
         end
         S_LEN: begin
            if (req_fire) begin
               cmd_out.take_length = 1'b1;
               priority if (status_in.length_over) begin
                  state_in = S_HEAD;
               end else if (status_in.length_zero) begin
                  state_in = S_CHK;
               end else begin
                  state_in = S_DATA;
               end
            end
         end
         S_DATA: begin
            if (req_fire) begin
               cmd_out.take_payload = 1'b1;
               if (status_in.payload_done) begin
                  state_in = S_CHK;
               end
            end
         end
         S_CHK: begin
            if (req_fire) begin
               if (status_in.check_ok) begin
                  cmd_out.fetch_first = 1'b1;
                  state_in            = S_SHOW;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_SHOW: begin
            if (rsp_fire) begin
               if (status_in.rsp_last) begin
                  state_in = S_HEAD;
               end else begin
                  cmd_out.fetch_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_HEAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HEAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/xcfr_datapath.sv @@
// Header registers, checksum, payload memory and output word for the frame receiver.
`timescale 1ns / 1ps

module xcfr_datapath #(
   parameter int unsigned MAX_PAYLOAD = xcfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_fire,
   input  logic [xcfr_pkg::BYTE_W-1:0]         csr_data,
   input  logic [xcfr_pkg::BYTE_W-1:0]         rx_byte,
   input  xcfr_pkg::xcfr_cmd_type              cmd_in,
   output xcfr_pkg::xcfr_status_type           status_out,
   output logic [xcfr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [0:0]                          rsp_tuser,
   output logic                                rsp_tlast
);
   import xcfr_pkg::*;

   localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int unsigned PAD_W = RSP_DATA_W - (2 * BYTE_W + LENGTH_W + INDEX_W);

   logic [BYTE_W-1:0] head_ff, head_in;
   logic [BYTE_W-1:0] check_ff, check_in;
   logic [BYTE_W-1:0] command_ff, command_in;
   logic [LW-1:0]     length_ff, length_in;
   logic [LW-1:0]     count_ff, count_in;
   logic [LW-1:0]     idx_ff, idx_in;
   logic [BYTE_W-1:0] rd_ff;
   logic [BYTE_W-1:0] payload_store_ff [MAX_PAYLOAD];

   logic [LW-1:0]     count_inc;
   logic [LW-1:0]     idx_inc;
   logic [AW-1:0]     rd_addr;
   logic              has_data;

   assign count_inc = count_ff + LW'(1);
   assign idx_inc   = idx_ff + LW'(1);
   assign rd_addr   = cmd_in.fetch_first ? '0 : idx_inc[AW-1:0];
   assign has_data  = (length_ff != '0);

   assign status_out.head_hit     = (rx_byte == head_ff);
   assign status_out.length_over  = (rx_byte > BYTE_W'(MAX_PAYLOAD));
   assign status_out.length_zero  = (rx_byte == '0);
   assign status_out.payload_done = (count_inc == length_ff);
   assign status_out.check_ok     = (rx_byte == check_ff);
   assign status_out.rsp_last     = (idx_inc == length_ff) || !has_data;

   always_comb begin
      head_in    = head_ff;
      check_in   = check_ff;
      command_in = command_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      if (csr_fire) begin
         head_in = csr_data;
      end
      // checksum starts from the head value latched at frame start
      if (cmd_in.start_frame) begin
         check_in = head_ff;
      end
      if (cmd_in.take_command) begin
         command_in = rx_byte;
         check_in   = check_ff ^ rx_byte;
      end
      if (cmd_in.take_length) begin
         check_in = check_ff ^ rx_byte;
         if (!status_out.length_over) begin
            length_in = rx_byte[LW-1:0];
            count_in  = '0;
         end
      end
      if (cmd_in.take_payload) begin
         check_in = check_ff ^ rx_byte;
         count_in = count_inc;
      end
      if (cmd_in.fetch_first) begin
         idx_in = '0;
      end
      if (cmd_in.fetch_next) begin
         idx_in = idx_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= HEAD_RESET;
         check_ff   <= '0;
         command_ff <= '0;
         length_ff  <= '0;
         count_ff   <= '0;
      end else begin
         head_ff    <= head_in;
         check_ff   <= check_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // payload memory: one write port while receiving, one registered read port for playout
   always_ff @(posedge clock) begin
      if (cmd_in.take_payload) begin
         payload_store_ff[count_ff[AW-1:0]] <= rx_byte;
      end
      if (cmd_in.fetch_first || cmd_in.fetch_next) begin
         rd_ff <= payload_store_ff[rd_addr];
      end
   end

   assign rsp_tdata = {PAD_W'(0),
                       INDEX_W'(idx_ff),
                       has_data ? rd_ff : BYTE_W'(0),
                       LENGTH_W'(length_ff),
                       command_ff};
   assign rsp_tuser = has_data;
   assign rsp_tlast = status_out.rsp_last;

endmodule

@@ design/xor_checked_frame_receiver.sv @@
// Top level of the XOR-checked, length-prefixed frame receiver.
`timescale 1ns / 1ps

// Byte-serial frame receiver. Each req word is one received byte. The block
// hunts for the head byte (csr register, reset 0xAA), then takes a command
// byte, a length byte, that many payload bytes and a checksum byte equal to
// the XOR of head, command, length and payload. A length above MAX_PAYLOAD
// drops the frame; a bad checksum drops it too. A good frame plays out on
// rsp as one word per payload byte with tlast on the final one; an empty
// frame gives a single word with has_data clear. While parsing, one byte is
// taken per cycle. After the checksum byte of a good frame req_tready drops
// and the frame plays out of the payload memory's registered read port at
// one word per cycle while rsp_tready is high; input is held until the
// last word of the frame has been taken. The head register may be
// rewritten at any time; a frame in progress keeps the head value it
// started with.

module xor_checked_frame_receiver #(
   parameter int unsigned MAX_PAYLOAD = xcfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // req: received bytes
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] rx_byte
   // rsp: frame playout
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] command, [13:8] length, [21:14] data_byte, [26:22] byte_index,
   // [31:27] zero
   output logic [xcfr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]                      rsp_tuser,  // [0] has_data
   output logic                            rsp_tlast,
   // csr: head byte write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [7:0]                      csr_data
);
   import xcfr_pkg::*;

   xcfr_cmd_type    cmd;
   xcfr_status_type status;
   logic            csr_fire;

   // head register is a plain flop: always ready
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   xcfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status_in  (status),
      .cmd_out    (cmd)
   );

   xcfr_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_fire   (csr_fire),
      .csr_data   (csr_data),
      .rx_byte    (req_tdata),
      .cmd_in     (cmd),
      .status_out (status),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ test/xor_checked_frame_receiver_tb.sv @@
// Self-checking testbench for the XOR-checked frame receiver, directed and random byte streams.
`timescale 1ns / 1ps

module xor_checked_frame_receiver_tb;
   import xcfr_pkg::*;

   localparam int unsigned PAYLOAD_MAX   = MAX_PAYLOAD_DEFAULT;
   localparam int          RANDOM_BYTES  = 90;
   localparam int          HEAD_SETTINGS = 4;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          CYCLE_LIMIT   = 200000;

   typedef enum logic [4:0] {
      HUNT_HEAD    = 5'b00001,
      TAKE_CMD     = 5'b00010,
      TAKE_LEN     = 5'b00100,
      TAKE_PAYLOAD = 5'b01000,
      TAKE_CHECK   = 5'b10000
   } rx_phase_type;

   // One expected playout word
   typedef struct packed {
      logic [7:0] command;
      logic [5:0] length;
      logic [7:0] data_byte;
      logic [4:0] byte_index;
      logic       has_data;
      logic       last;
   } frame_word_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;   // [7:0] rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [7:0] command, [13:8] length, [21:14] data_byte, [26:22] byte_index
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;          // [0] has_data
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [7:0]            csr_data   = '0;    // [7:0] head_byte

   // Shadow of the receiver's parser
   logic [7:0]     shadow_head = HEAD_RESET;
   rx_phase_type   rx_phase    = HUNT_HEAD;
   logic [7:0]     rx_command  = '0;
   logic [5:0]     rx_length   = '0;
   int             rx_count    = 0;
   logic [7:0]     rx_check    = '0;
   logic [7:0]     rx_store [PAYLOAD_MAX];
   frame_word_type expected_words [$];

   logic [7:0]  frame_body [$];
   int errors         = 0;
   int bytes_sent     = 0;
   int words_checked  = 0;
   int frames_good    = 0;
   int frames_dropped = 0;
   int head_writes    = 0;
   int cycle_count    = 0;
   int send_calm      = 0;
   int rsp_calm       = 0;

   xor_checked_frame_receiver #(
      .MAX_PAYLOAD(PAYLOAD_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, and now and then a calm stretch with none
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(15, 30);
   endfunction

   // Advance the parser shadow by one received byte, queue any playout words
   task automatic track_rx_byte(input logic [7:0] b);
      frame_word_type w;
      case (rx_phase)
         HUNT_HEAD: begin
            if (b == shadow_head) begin
               rx_check = shadow_head;   // head latched here, later writes don't matter
               rx_phase = TAKE_CMD;
            end
         end
         TAKE_CMD: begin
            rx_command = b;
            rx_check ^= b;
            rx_phase = TAKE_LEN;
         end
         TAKE_LEN: begin
            rx_check ^= b;
            if (b > PAYLOAD_MAX) begin
               frames_dropped++;
               rx_phase = HUNT_HEAD;
            end else begin
               rx_length = b[5:0];
               rx_count = 0;
               rx_phase = (b == 8'd0) ? TAKE_CHECK : TAKE_PAYLOAD;
            end
         end
         TAKE_PAYLOAD: begin
            if (rx_count < PAYLOAD_MAX) rx_store[rx_count] = b;
            rx_count++;
            rx_check ^= b;
            if (rx_count >= rx_length) rx_phase = TAKE_CHECK;
         end
         TAKE_CHECK: begin
            if (b == rx_check) begin
               frames_good++;
               if (rx_length == 6'd0) begin
                  // empty frame: one word, no data
                  w = '{rx_command, 6'd0, 8'd0, 5'd0, 1'b0, 1'b1};
                  expected_words.push_back(w);
               end else begin
                  for (int i = 0; i < rx_length; i++) begin
                     w = '{rx_command, rx_length, rx_store[i], 5'(i), 1'b1,
                           (i + 1 == rx_length)};
                     expected_words.push_back(w);
                  end
               end
            end else begin
               frames_dropped++;
            end
            rx_phase = HUNT_HEAD;
         end
         default: rx_phase = HUNT_HEAD;
      endcase
   endtask

   // Offer one byte, wait for the handshake, then maybe idle
   task automatic send_rx_byte(input logic [7:0] b);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      track_rx_byte(b);
      bytes_sent++;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Head, command, length, the first body_bytes of frame_body, then the XOR check byte
   task automatic send_frame(input logic [7:0] head, input logic [7:0] cmd,
                             input logic [7:0] len, input int body_bytes,
                             input bit corrupt);
      logic [7:0] sum;
      sum = head ^ cmd ^ len;
      send_rx_byte(head);
      send_rx_byte(cmd);
      send_rx_byte(len);
      for (int i = 0; i < body_bytes; i++) begin
         sum ^= frame_body[i];
         send_rx_byte(frame_body[i]);
      end
      if (corrupt) sum ^= 8'(1 << $urandom_range(0, 7));
      send_rx_byte(sum);
   endtask

   task automatic fill_body(input int n);
      frame_body.delete();
      repeat (n) frame_body.push_back(8'($urandom));
   endtask

   // Stop offering bytes and let every queued word play out
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_head(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_head = value;
      head_writes++;
   endtask

   // Reset head value, line noise first, then a frame with no payload
   task automatic test_empty_frame();
      send_rx_byte(8'h00);
      send_rx_byte(8'h55);
      frame_body.delete();
      send_frame(shadow_head, 8'h00, 8'd0, 0, 1'b0);
   endtask

   task automatic test_single_byte_frame();
      frame_body = {8'hFF};
      send_frame(shadow_head, 8'hFF, 8'd1, 1, 1'b0);
   endtask

   // Length just over the limit and at the top of the byte: both dropped
   task automatic test_oversized_length();
      frame_body.delete();
      send_frame(shadow_head, 8'h01, 8'(PAYLOAD_MAX + 1), 0, 1'b0);
      send_frame(shadow_head, 8'h02, 8'hFF, 0, 1'b0);
   endtask

   task automatic test_bad_checksum();
      frame_body = {8'h12, 8'h34};
      send_frame(shadow_head, 8'h7E, 8'd2, 2, 1'b1);
   endtask

   // Head register at both extremes, and a rewrite while a frame is half parsed
   task automatic test_head_register();
      wait_for_idle();
      write_head(8'h00);
      frame_body.delete();
      send_frame(8'h00, 8'h5A, 8'd0, 0, 1'b0);
      send_rx_byte(8'h00);
      send_rx_byte(8'h3C);
      wait_for_idle();
      write_head(8'hFF);
      // check byte still built on the old head
      send_rx_byte(8'h01);
      send_rx_byte(8'h81);
      send_rx_byte(8'h00 ^ 8'h3C ^ 8'h01 ^ 8'h81);
      send_frame(8'hFF, 8'hC3, 8'd0, 0, 1'b0);
   endtask

   // Mostly good frames, small lengths, a few full ones; the rest noise and damage
   task automatic send_random_frame();
      int kind;
      int n;
      kind = $urandom_range(0, 99);
      n = $urandom_range(0, 99);
      if (n < 6) n = PAYLOAD_MAX;
      else if (n < 10) n = PAYLOAD_MAX - 1;
      else n = $urandom_range(0, 6);
      fill_body(n);
      if (kind < 8) begin
         repeat ($urandom_range(1, 3)) send_rx_byte(8'($urandom));
      end else if (kind < 14) begin
         send_frame(shadow_head, 8'($urandom), 8'($urandom_range(PAYLOAD_MAX + 1, 255)), 0,
                    1'b0);
      end else if (kind < 22) begin
         send_frame(shadow_head, 8'($urandom), 8'(n), n, 1'b1);
      end else if (kind < 27 && n > 0) begin
         // truncated: the check byte and what follows land in the payload
         send_frame(shadow_head, 8'($urandom), 8'(n), $urandom_range(0, n - 1), 1'b0);
      end else begin
         send_frame(shadow_head, 8'($urandom), 8'(n), n, 1'b0);
      end
   endtask

   task automatic test_random_stream();
      int first_byte;
      first_byte = bytes_sent;
      for (int p = 0; p < HEAD_SETTINGS; p++) begin
         wait_for_idle();
         write_head(8'($urandom));
         if (p == 0) begin
            fill_body(PAYLOAD_MAX);
            send_frame(shadow_head, 8'($urandom), 8'(PAYLOAD_MAX), PAYLOAD_MAX, 1'b0);
         end
         while (bytes_sent - first_byte < (p + 1) * RANDOM_BYTES / HEAD_SETTINGS)
            send_random_frame();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // Playout check against the oldest queued word
   always @(posedge clock) begin
      frame_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: word with none expected, expected nothing, actual tdata 0x%08h",
                     $time, rsp_tdata);
         end else begin
            w = expected_words.pop_front();
            check_field("command", w.command, rsp_tdata[7:0]);
            check_field("length", w.length, rsp_tdata[13:8]);
            check_field("data_byte", w.data_byte, rsp_tdata[21:14]);
            check_field("byte_index", w.byte_index, rsp_tdata[26:22]);
            check_field("has_data", w.has_data, rsp_tuser[0]);
            check_field("last", w.last, rsp_tlast);
            words_checked++;
         end
      end
   end

   // Receiver back-pressure
   initial begin
      int stall;
      forever begin
         @(posedge clock);
         stall = pick_gap(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d words outstanding", $time, expected_words.size());
         $display("xor_checked_frame_receiver_tb: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_frame();
      test_single_byte_frame();
      test_oversized_length();
      test_bad_checksum();
      test_head_register();
      test_random_stream();
      wait_for_idle();
      if (expected_words.size() != 0) begin
         errors++;
         $display("%0t: %0d words never arrived", $time, expected_words.size());
      end
      $display("Sent %0d bytes under %0d head settings: %0d frames good, %0d dropped.",
               bytes_sent, head_writes + 1, frames_good, frames_dropped);
      $display("Checked %0d playout words, %0d mismatches.", words_checked, errors);
      if (errors == 0) begin
         $display("xor_checked_frame_receiver_tb: done, clean");
      end else begin
         $display("xor_checked_frame_receiver_tb: done, errors");
      end
      $finish;
   end

endmodule
